// ===== hw/rtl/cpmd_pkg.sv =====
// Shared constants, command and status types of the closest pair unit.
package cpmd_pkg;

  // Capacity of the value store and the widths that follow from it.
  localparam int MAX_ITEMS = 4096;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int IDX_W     = $clog2(MAX_ITEMS + 1);

  // Fixed field widths.
  localparam int VAL_W = 27;
  localparam int CNT_W = 13;

  // Stream payload layout.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;

  localparam int FIRST_LSB  = 0;
  localparam int SECOND_LSB = FIRST_LSB + VAL_W;
  localparam int DIFF_LSB   = SECOND_LSB + VAL_W;
  localparam int COUNT_LSB  = DIFF_LSB + VAL_W;
  localparam int PAYLOAD_W  = COUNT_LSB + CNT_W;

  localparam int USER_FOUND_BIT = 0;
  localparam int USER_OVF_BIT   = 1;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    ST_LOAD    = 5'b00001,
    ST_START   = 5'b00010,
    ST_FETCH_A = 5'b00100,
    ST_SCAN    = 5'b01000,
    ST_PUBLISH = 5'b10000
  } cpmd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take input requests into the store
    logic rd_first;  // restart the outer index at zero and read it
    logic cap_a;     // latch the outer value and read the first inner one
    logic cmp;       // compare the outer value with the current inner one
    logic adv_j;     // step the inner index
    logic adv_i;     // step the outer index
    logic publish;   // load the result register and empty the set
  } cpmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_items; // fewer than two items held
    logic inner_end; // inner index is at the last held item
    logic outer_end; // outer index is at the second to last held item
    logic out_free;  // result register can take a new request
  } cpmd_status_t;

endpackage

// ===== hw/rtl/cpmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cpmd_ctrl.sv =====
// Controller state machine that sequences loading, the pair scan and publishing.
module cpmd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  input  cpmd_pkg::cpmd_status_t status_i,
  output cpmd_pkg::cpmd_cmd_t    cmd_o
);

  cpmd_pkg::cpmd_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpmd_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      cpmd_pkg::ST_LOAD: begin
        cmd_o.accept = 1'b1;
        if (in_valid_i && in_last_i) begin
          state_d = cpmd_pkg::ST_START;
        end
      end
      cpmd_pkg::ST_START: begin
        if (status_i.few_items) begin
          state_d = cpmd_pkg::ST_PUBLISH;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_d        = cpmd_pkg::ST_FETCH_A;
        end
      end
      cpmd_pkg::ST_FETCH_A: begin
        cmd_o.cap_a = 1'b1;
        state_d     = cpmd_pkg::ST_SCAN;
      end
      cpmd_pkg::ST_SCAN: begin
        cmd_o.cmp = 1'b1;
        if (status_i.inner_end) begin
          if (status_i.outer_end) begin
            state_d = cpmd_pkg::ST_PUBLISH;
          end else begin
            cmd_o.adv_i = 1'b1;
            state_d     = cpmd_pkg::ST_FETCH_A;
          end
        end else begin
          cmd_o.adv_j = 1'b1;
        end
      end
      cpmd_pkg::ST_PUBLISH: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = cpmd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = cpmd_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cpmd_datapath.sv =====
// Datapath: value store, scan indexes, running best pair and result register.
module cpmd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cpmd_pkg::cpmd_cmd_t                cmd_i,
  output cpmd_pkg::cpmd_status_t             status_o,
  input  logic                               in_valid_i,
  input  logic [cpmd_pkg::VAL_W-1:0]         in_value_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [cpmd_pkg::PAYLOAD_W-1:0]     out_payload_o,
  output logic [cpmd_pkg::OUT_USER_W-1:0]    out_user_o
);

  localparam int EXT_W = (cpmd_pkg::IDX_W > cpmd_pkg::CNT_W) ?
                         cpmd_pkg::IDX_W : cpmd_pkg::CNT_W;

  logic [cpmd_pkg::IDX_W-1:0]  count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic [cpmd_pkg::ADDR_W-1:0] i_q, i_d, j_q, j_d;
  logic [cpmd_pkg::ADDR_W-1:0] i_next, j_next, rd_addr;
  logic [cpmd_pkg::VAL_W-1:0]  rd_data;
  logic [cpmd_pkg::VAL_W-1:0]  a_q, best_q, first_q, second_q;
  logic                        found_q;
  logic [cpmd_pkg::VAL_W-1:0]  diff;
  logic                        better;
  logic                        wr_en, has_room;
  logic [EXT_W-1:0]            count_ext;
  logic                        out_valid_q;
  logic [cpmd_pkg::PAYLOAD_W-1:0]  out_payload_q;
  logic [cpmd_pkg::OUT_USER_W-1:0] out_user_q;

  // Store fill control: items beyond capacity are dropped and flagged.
  assign has_room = (count_q < cpmd_pkg::IDX_W'(cpmd_pkg::MAX_ITEMS));
  assign wr_en    = cmd_i.accept && in_valid_i && has_room;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.publish) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.accept && in_valid_i) begin
      if (has_room) begin
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Scan index stepping and read address selection.
  assign i_next = i_q + 1'b1;
  assign j_next = j_q + 1'b1;

  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    rd_addr = j_q;
    if (cmd_i.rd_first) begin
      i_d     = '0;
      rd_addr = '0;
    end else if (cmd_i.cap_a) begin
      j_d     = i_next;
      rd_addr = i_next;
    end else if (cmd_i.adv_j) begin
      j_d     = j_next;
      rd_addr = j_next;
    end else if (cmd_i.adv_i) begin
      i_d     = i_next;
      rd_addr = i_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  cpmd_ram #(
    .WIDTH (cpmd_pkg::VAL_W),
    .DEPTH (cpmd_pkg::MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[cpmd_pkg::ADDR_W-1:0]),
    .wdata_i (in_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Distance of the current pair and the strict improvement test.
  assign diff   = (a_q >= rd_data) ? (a_q - rd_data) : (rd_data - a_q);
  assign better = !found_q || (diff < best_q);

  // Running best pair; the first pair always wins, ties keep the older one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.publish) begin
      found_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_q <= rd_data;
    end
    if (cmd_i.cmp && better) begin
      best_q   <= diff;
      first_q  <= a_q;
      second_q <= rd_data;
    end
  end

  // Status toward the controller.
  assign status_o.few_items = (count_q < cpmd_pkg::IDX_W'(2));
  assign status_o.inner_end = (cpmd_pkg::IDX_W'(j_q) == count_q - 1'b1);
  assign status_o.outer_end = (cpmd_pkg::IDX_W'(i_q) + cpmd_pkg::IDX_W'(2) == count_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Result register, which holds a request until the consumer takes it.
  assign count_ext = EXT_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_payload_q <= {count_ext[cpmd_pkg::CNT_W-1:0],
                        found_q ? best_q   : '0,
                        found_q ? second_q : '0,
                        found_q ? first_q  : '0};
      out_user_q[cpmd_pkg::USER_FOUND_BIT] <= found_q;
      out_user_q[cpmd_pkg::USER_OVF_BIT]   <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_payload_q;
  assign out_user_o    = out_user_q;

endmodule

// ===== hw/rtl/closest_pair_min_difference_unit.sv =====
// Top level of the closest pair unit: stream ports, controller and datapath.
// Items stream in one per cycle and are stored in arrival order; the item
// flagged with tlast closes the set. The unit then compares every pair of
// held items, one compare per cycle outside the fetch of each outer value,
// through the single read port of the value store, and returns the earliest
// pair with the smallest absolute difference together with the item count
// and an overflow flag. No input is accepted during the search; the
// finished result waits in an output register while the next set loads.
// Items beyond the store capacity of 4096 are dropped and flagged.
module closest_pair_min_difference_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream. tdata: sample_value [26:0], zero fill above.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [cpmd_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  // Result stream. tdata: first_value [26:0], second_value [53:27],
  // min_difference [80:54], item_count [93:81], zero fill above.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [cpmd_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: pair_found [0], overflowed [1].
  output logic [cpmd_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);

  cpmd_pkg::cpmd_cmd_t    cmd;
  cpmd_pkg::cpmd_status_t status;
  logic [cpmd_pkg::PAYLOAD_W-1:0] payload;

  // Sequencer.
  cpmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, compare and result logic.
  cpmd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_valid_i    (s_axis_tvalid_i),
    .in_value_i    (s_axis_tdata_i[cpmd_pkg::VAL_W-1:0]),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_payload_o (payload),
    .out_user_o    (m_axis_tuser_o)
  );

  assign s_axis_tready_o = cmd.accept;
  assign m_axis_tdata_o  = cpmd_pkg::OUT_DATA_W'(payload);

endmodule

// ===== hw/rtl/cpmd_checker.sv =====
// Port-level assertions for the closest pair unit and their bind.
module cpmd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [cpmd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [cpmd_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  logic [cpmd_pkg::VAL_W-1:0] first_v, second_v, diff_v;

  assign first_v  = m_axis_tdata_o[cpmd_pkg::FIRST_LSB  +: cpmd_pkg::VAL_W];
  assign second_v = m_axis_tdata_o[cpmd_pkg::SECOND_LSB +: cpmd_pkg::VAL_W];
  assign diff_v   = m_axis_tdata_o[cpmd_pkg::DIFF_LSB   +: cpmd_pkg::VAL_W];

  // A closing request starts the search, so input stalls in the next cycle.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input accepted right after the closing item");

  // A stalled result holds its payload.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Without a pair the value fields are zero.
  a_no_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[cpmd_pkg::USER_FOUND_BIT] |->
      first_v == '0 && second_v == '0 && diff_v == '0)
    else $error("nonzero fields without a pair");

  // The reported difference belongs to the reported pair.
  a_diff_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[cpmd_pkg::USER_FOUND_BIT] |->
      ((first_v >= second_v) ? (first_v - second_v) : (second_v - first_v)) == diff_v)
    else $error("difference does not match the pair");

endmodule

bind closest_pair_min_difference_unit cpmd_checker u_cpmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
